// ----- sv/mpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// mpsd_pkg
// Shared types and constants for the point to segment distance block.
// ----------------------------------------------------------------------------
package mpsd_pkg;

  localparam int CoordW = 16;
  localparam int DistW  = 37;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_QUERY  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROT,
    S_DRAIN,
    S_DONE
  } state_t;

  // one stored segment
  typedef struct packed {
    logic signed [CoordW-1:0] ox, oy, oz;
    logic signed [CoordW-1:0] vx, vy, vz;
    logic signed [CoordW-1:0] lo, hi;
  } seg_t;

  // control from sequencer to each cell
  typedef struct packed {
    logic rotate;  // shift whole row toward cell 0 (tail wraps)
    logic load;    // load new segment into selected cell
    logic close;   // remove: cell takes neighbor only at/after index
  } cell_ctl_t;

  // floor((x + 2^13) / 2^14)
  function automatic logic signed [35:0] round14(input logic signed [49:0] x);
    logic signed [49:0] y;
    y = x + 50'sd8192;
    return y[49:14];
  endfunction

endpackage

// ----- sv/mpsd_cell.sv -----
// ----------------------------------------------------------------------------
// mpsd_cell
// One table slot; hands its segment to the lower neighbor when rotating.
// ----------------------------------------------------------------------------
module mpsd_cell (
  input  logic              clk,
  input  mpsd_pkg::cell_ctl_t ctl,
  input  logic              sel_load,
  input  logic              sel_shift,
  input  mpsd_pkg::seg_t    new_seg,
  input  mpsd_pkg::seg_t    from_up,
  output mpsd_pkg::seg_t    seg
);

  // advance, load or close the gap
  always_ff @(posedge clk) begin
    if (ctl.rotate) begin
      seg <= from_up;
    end else if (ctl.load && sel_load) begin
      seg <= new_seg;
    end else if (ctl.close && sel_shift) begin
      seg <= from_up;
    end
  end

endmodule

// ----- sv/mpsd_dist.sv -----
// ----------------------------------------------------------------------------
// mpsd_dist
// Pipelined squared distance from a point to one clamped segment.
// ----------------------------------------------------------------------------
module mpsd_dist (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  mpsd_pkg::seg_t            seg,
  input  logic signed [15:0]        px,
  input  logic signed [15:0]        py,
  input  logic signed [15:0]        pz,
  output logic                      out_valid,
  output logic [mpsd_pkg::DistW-1:0] dist2
);

  logic [4:0] vld;
  logic signed [16:0] d1x, d1y, d1z, d2x, d2y, d2z, d3x, d3y, d3z, d4x, d4y, d4z;
  logic signed [15:0] vx1, vy1, vz1, vx2, vy2, vz2, vx3, vy3, vz3, vx4, vy4, vz4;
  logic signed [15:0] lo1, hi1, lo2, hi2, lo3, hi3;
  logic signed [32:0] mx, my, mz;
  logic signed [35:0] t2;
  logic signed [35:0] tc;
  logic signed [15:0] t3;
  logic signed [32:0] wx, wy, wz;
  logic signed [18:0] ex, ey, ez;
  logic signed [37:0] qx, qy, qz;
  logic [37:0] sq;
  logic signed [49:0] dot;

  assign dot = 50'(mx) + 50'(my) + 50'(mz);

  // clamp parameter, start bound wins
  always_comb begin
    tc = t2;
    if (t2 < 36'(lo3)) tc = 36'(lo3);
    else if (t2 > 36'(hi3)) tc = 36'(hi3);
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[3:0], in_valid};
  end

  always_ff @(posedge clk) begin
    // stage 1: offset
    d1x <= 17'(px) - 17'(seg.ox);
    d1y <= 17'(py) - 17'(seg.oy);
    d1z <= 17'(pz) - 17'(seg.oz);
    vx1 <= seg.vx; vy1 <= seg.vy; vz1 <= seg.vz;
    lo1 <= seg.lo; hi1 <= seg.hi;
    // stage 2: products for dot
    mx <= d1x * vx1; my <= d1y * vy1; mz <= d1z * vz1;
    d2x <= d1x; d2y <= d1y; d2z <= d1z;
    vx2 <= vx1; vy2 <= vy1; vz2 <= vz1;
    lo2 <= lo1; hi2 <= hi1;
    // stage 3: round and clamp are split across 3/4
    t2  <= mpsd_pkg::round14(dot);
    d3x <= d2x; d3y <= d2y; d3z <= d2z;
    vx3 <= vx2; vy3 <= vy2; vz3 <= vz2;
    lo3 <= lo2; hi3 <= hi2;
    // stage 4: foot point offset
    t3  <= tc[15:0];
    d4x <= d3x; d4y <= d3y; d4z <= d3z;
    vx4 <= vx3; vy4 <= vy3; vz4 <= vz3;
    // stage 5: residual
    ex <= 19'(d4x) - 19'(mpsd_pkg::round14(50'(wx)));
    ey <= 19'(d4y) - 19'(mpsd_pkg::round14(50'(wy)));
    ez <= 19'(d4z) - 19'(mpsd_pkg::round14(50'(wz)));
  end

  assign wx = t3 * vx4;
  assign wy = t3 * vy4;
  assign wz = t3 * vz4;

  // square each residual at full width, then sum and saturate
  assign qx = ex * ex;
  assign qy = ey * ey;
  assign qz = ez * ez;
  assign sq = $unsigned(qx) + $unsigned(qy) + $unsigned(qz);
  assign dist2 = sq[37] ? mpsd_pkg::DistMax : sq[36:0];
  assign out_valid = vld[4];

endmodule

// ----- sv/min_point_segment_distance.sv -----
// ----------------------------------------------------------------------------
// min_point_segment_distance
// Table of 3D segments held in a row of cells; queries return min distance^2.
// ----------------------------------------------------------------------------
// Clear, append and remove requests, and a query on an empty table, go from
// acceptance to the done state, from which the result is registered onto the
// ports. A query rotates the cell row once round, feeding the head cell into a
// 5-stage distance unit, then drains the unit before the done state. busy is
// high until the result cycle, in which the next request may already be
// accepted; the result appears with done for one cycle and cannot be held off.
module min_point_segment_distance #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic [1:0]         action,
  input  logic signed [15:0] origin_x,
  input  logic signed [15:0] origin_y,
  input  logic signed [15:0] origin_z,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic signed [15:0] t_start,
  input  logic signed [15:0] t_end,
  input  logic [5:0]         entry_index,
  output logic [36:0]        min_dist2,
  output logic               found,
  output logic [1:0]         status
);

  localparam int CntW = $clog2(MAX_SEGMENTS + 1);

  mpsd_pkg::state_t state, state_next;
  logic [CntW-1:0] seg_count, rot_cnt, rot_cnt_next;
  logic [2:0] drain, drain_next;
  mpsd_pkg::seg_t cells [MAX_SEGMENTS];
  mpsd_pkg::seg_t new_seg;
  mpsd_pkg::cell_ctl_t ctl;
  logic signed [15:0] px, py, pz;
  logic [1:0] act_q;
  logic [5:0] idx_q;
  logic d_valid, d_in_valid;
  logic [36:0] d_dist2, best;
  logic have;
  logic [1:0] st;

  // hold request payload
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      act_q <= action; idx_q <= entry_index;
      px <= origin_x; py <= origin_y; pz <= origin_z;
      new_seg <= '{ox: origin_x, oy: origin_y, oz: origin_z, vx: dir_x,
                   vy: dir_y, vz: dir_z, lo: t_start, hi: t_end};
    end
  end

  // row of cells; the head cell wraps to the top during rotation
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    mpsd_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .sel_load (CntW'(i) == seg_count),
      .sel_shift(CntW'(i) >= CntW'(idx_q)),
      .new_seg  (new_seg),
      .from_up  (cells[(i + 1) % MAX_SEGMENTS]),
      .seg      (cells[i])
    );
  end

  mpsd_dist u_dist (
    .clk(clk), .rst(rst), .in_valid(d_in_valid), .seg(cells[0]),
    .px(px), .py(py), .pz(pz), .out_valid(d_valid), .dist2(d_dist2)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mpsd_pkg::S_IDLE; seg_count <= '0; rot_cnt <= '0; drain <= '0;
    end else begin
      state <= state_next; rot_cnt <= rot_cnt_next; drain <= drain_next;
      if (state == mpsd_pkg::S_IDLE && start) begin
        unique case (mpsd_pkg::action_t'(action))
          mpsd_pkg::ACT_CLEAR:  seg_count <= '0;
          mpsd_pkg::ACT_APPEND: ;
          mpsd_pkg::ACT_REMOVE: ;
          mpsd_pkg::ACT_QUERY:  ;
          default: ;
        endcase
      end
      if (ctl.load && seg_count < CntW'(MAX_SEGMENTS)) seg_count <= seg_count + 1'b1;
      if (ctl.close) seg_count <= seg_count - 1'b1;
    end
  end

  // next state and cell control
  always_comb begin
    state_next = state; rot_cnt_next = rot_cnt; drain_next = drain;
    ctl = '0; d_in_valid = 1'b0; st = mpsd_pkg::ST_OK;
    unique case (state)
      mpsd_pkg::S_IDLE: if (start) begin
        state_next = mpsd_pkg::S_DONE;
        if (mpsd_pkg::action_t'(action) == mpsd_pkg::ACT_QUERY && seg_count != '0) begin
          state_next = mpsd_pkg::S_ROT; rot_cnt_next = '0;
        end
      end
      mpsd_pkg::S_ROT: begin
        ctl.rotate = 1'b1;
        d_in_valid = rot_cnt < seg_count;
        rot_cnt_next = rot_cnt + 1'b1;
        if (rot_cnt == CntW'(MAX_SEGMENTS - 1)) begin
          state_next = mpsd_pkg::S_DRAIN; drain_next = '0;
        end
      end
      mpsd_pkg::S_DRAIN: begin
        drain_next = drain + 1'b1;
        if (drain == 3'd5) state_next = mpsd_pkg::S_DONE;
      end
      mpsd_pkg::S_DONE: begin
        state_next = mpsd_pkg::S_IDLE;
        unique case (mpsd_pkg::action_t'(act_q))
          mpsd_pkg::ACT_APPEND: if (seg_count >= CntW'(MAX_SEGMENTS)) st = mpsd_pkg::ST_FULL;
            else ctl.load = 1'b1;
          mpsd_pkg::ACT_REMOVE: if (CntW'(idx_q) >= seg_count || idx_q > 6'(MAX_SEGMENTS - 1))
              st = mpsd_pkg::ST_RANGE;
            else ctl.close = 1'b1;
          mpsd_pkg::ACT_QUERY: if (!have) st = mpsd_pkg::ST_EMPTY;
          default: ;
        endcase
      end
      default: state_next = mpsd_pkg::S_IDLE;
    endcase
  end

  // track running minimum
  always_ff @(posedge clk) begin
    if (rst) have <= 1'b0;
    else if (state == mpsd_pkg::S_IDLE) have <= 1'b0;
    else if (d_valid) begin
      have <= 1'b1;
      if (!have || d_dist2 < best) best <= d_dist2;
    end
  end

  assign busy = state != mpsd_pkg::S_IDLE;

  // register result for one cycle
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= state == mpsd_pkg::S_DONE;
    status <= st;
    found <= have && act_q == mpsd_pkg::ACT_QUERY;
    min_dist2 <= (have && act_q == mpsd_pkg::ACT_QUERY) ? best : '0;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    seg_count <= CntW'(MAX_SEGMENTS)) else $error("segment count overflow");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");
  a_no_feed_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !d_in_valid) else $error("distance fed while idle");
`endif

endmodule

// ----- test/min_point_segment_distance_chk.sv -----
// ----------------------------------------------------------------------------
// min_point_segment_distance_chk
// Watches the request and result ports of the segment distance block, keeps
// a shadow segment table, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module min_point_segment_distance_chk (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               done,
  input  logic [1:0]         action,
  input  logic signed [15:0] origin_x,
  input  logic signed [15:0] origin_y,
  input  logic signed [15:0] origin_z,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic signed [15:0] t_start,
  input  logic signed [15:0] t_end,
  input  logic [5:0]         entry_index,
  input  logic [36:0]        min_dist2,
  input  logic               found,
  input  logic [1:0]         status,
  output int                 fail_count,
  output int                 pending,
  output int                 query_hits
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TableDepth = 64;

  typedef struct {
    logic [36:0]       dist2;
    logic              hit;
    mpsd_pkg::status_t st;
  } answer_t;

  mpsd_pkg::seg_t shadow_tab[TableDepth];
  int             shadow_count;
  answer_t        answer_q[$];

  assign pending = answer_q.size();

  // floor((x + 2^13) / 2^14) in plain integer terms
  function automatic longint round_q14(input longint x);
    return (x + 64'sd8192) >>> 14;
  endfunction

  function automatic longint seg_dist2(input mpsd_pkg::seg_t s, input longint px,
                                       input longint py, input longint pz);
    longint ddx, ddy, ddz, dot, t, ex, ey, ez, sum;
    ddx = px - longint'(s.ox);
    ddy = py - longint'(s.oy);
    ddz = pz - longint'(s.oz);
    dot = ddx * s.vx + ddy * s.vy + ddz * s.vz;
    t = round_q14(dot);
    // clamp, lower bound wins
    if (t < longint'(s.lo)) t = s.lo;
    else if (t > longint'(s.hi)) t = s.hi;
    ex = ddx - round_q14(t * s.vx);
    ey = ddy - round_q14(t * s.vy);
    ez = ddz - round_q14(t * s.vz);
    sum = ex * ex + ey * ey + ez * ez;
    if (sum > 64'sh1F_FFFF_FFFF) sum = 64'sh1F_FFFF_FFFF;
    return sum;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // predict each accepted request
  always @(posedge clk) begin
    answer_t a;
    longint best, d;
    if (rst) begin
      shadow_count = 0;
    end else if (start && !busy) begin
      a.dist2 = '0;
      a.hit = 1'b0;
      a.st = mpsd_pkg::ST_OK;
      case (mpsd_pkg::action_t'(action))
        mpsd_pkg::ACT_CLEAR: shadow_count = 0;
        mpsd_pkg::ACT_APPEND: begin
          if (shadow_count >= TableDepth) begin
            a.st = mpsd_pkg::ST_FULL;
          end else begin
            shadow_tab[shadow_count] = '{origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                                         t_start, t_end};
            shadow_count++;
          end
        end
        mpsd_pkg::ACT_REMOVE: begin
          if (entry_index >= shadow_count) begin
            a.st = mpsd_pkg::ST_RANGE;
          end else begin
            for (int i = entry_index; i + 1 < shadow_count; i++)
              shadow_tab[i] = shadow_tab[i + 1];
            shadow_count--;
          end
        end
        default: begin
          if (shadow_count == 0) begin
            a.st = mpsd_pkg::ST_EMPTY;
          end else begin
            best = 0;
            for (int i = 0; i < shadow_count; i++) begin
              d = seg_dist2(shadow_tab[i], origin_x, origin_y, origin_z);
              if (i == 0 || d < best) best = d;
            end
            a.dist2 = best[36:0];
            a.hit = 1'b1;
            query_hits++;
          end
        end
      endcase
      answer_q.push_back(a);
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    answer_t a;
    if (!rst && done) begin
      if (answer_q.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        a = answer_q.pop_front();
        if (min_dist2 !== a.dist2) report("min_dist2", min_dist2, a.dist2);
        if (found !== a.hit) report("found", found, a.hit);
        if (status !== a.st) report("status", status, a.st);
      end
    end
  end

  initial begin
    fail_count = 0;
    query_hits = 0;
  end
endmodule

// ----- test/min_point_segment_distance_tb.sv -----
// ----------------------------------------------------------------------------
// min_point_segment_distance_tb
// Drives clear, append, remove and query requests, some with random gaps, into the
// segment distance block; a checker beside it predicts and compares results.
// ----------------------------------------------------------------------------
module min_point_segment_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  NumRandom = 2000;
  localparam longint CycleLimit = 2_000_000;

  logic clk = 1'b0, rst = 1'b1, start = 1'b0;
  logic busy, done, found;
  logic [1:0] action = '0;
  logic signed [15:0] origin_x = '0, origin_y = '0, origin_z = '0;
  logic signed [15:0] dir_x = '0, dir_y = '0, dir_z = '0;
  logic signed [15:0] t_start = '0, t_end = '0;
  logic [5:0] entry_index = '0;
  logic [36:0] min_dist2;
  logic [1:0] status;
  int fail_count, pending, query_hits;
  int model_count;
  int issued;
  longint cycles;

  always #4 clk = ~clk;

  min_point_segment_distance dut (.*);
  min_point_segment_distance_chk chk (.*);

  // end the run at the cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("min_point_segment_distance test failed");
      $finish;
    end
  end

  function automatic logic signed [15:0] rand_dir();
    case ($urandom_range(0, 3))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  // present one request and wait for its acceptance
  task automatic send(input mpsd_pkg::action_t act, input logic signed [15:0] px, py, pz,
                      input logic signed [15:0] vx, vy, vz, lo, hi, input logic [5:0] idx,
                      input bit gaps);
    int g;
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      g = $urandom_range(1, 5);
      repeat (g) @(negedge clk);
    end
    action <= act;
    origin_x <= px; origin_y <= py; origin_z <= pz;
    dir_x <= vx; dir_y <= vy; dir_z <= vz;
    t_start <= lo; t_end <= hi;
    entry_index <= idx;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    issued++;
    case (act)
      mpsd_pkg::ACT_CLEAR: model_count = 0;
      mpsd_pkg::ACT_APPEND: if (model_count < 64) model_count++;
      mpsd_pkg::ACT_REMOVE: if (idx < model_count) model_count--;
      default: ;
    endcase
  endtask

  task automatic send_random(input bit gaps);
    int r;
    mpsd_pkg::action_t act;
    logic signed [15:0] lo, hi;
    r = $urandom_range(0, 99);
    if (r < 2) act = mpsd_pkg::ACT_CLEAR;
    else if (r < 30) act = mpsd_pkg::ACT_APPEND;
    else if (r < 45) act = mpsd_pkg::ACT_REMOVE;
    else act = mpsd_pkg::ACT_QUERY;
    lo = 16'($urandom);
    hi = 16'($urandom);
    if ($urandom_range(0, 3) != 0 && lo > hi) begin
      lo = hi;
      hi = 16'($urandom);
      if (lo > hi) lo = -hi;
    end
    // keep the table small most of the time
    if (act == mpsd_pkg::ACT_APPEND && model_count > 12 && $urandom_range(0, 9) != 0)
      act = mpsd_pkg::ACT_REMOVE;
    send(act, 16'($urandom), 16'($urandom), 16'($urandom), rand_dir(), rand_dir(), rand_dir(),
         lo, hi, (model_count > 0 && $urandom_range(0, 4) != 0) ?
         6'($urandom_range(0, model_count - 1)) : 6'($urandom), gaps);
  endtask

  initial begin
    int wait_cycles;
    cycles = 0;
    model_count = 0;
    issued = 0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // directed: empty table, bad index, extremes, full table, clamping
    send(mpsd_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(mpsd_pkg::ACT_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(mpsd_pkg::ACT_APPEND, -16'sd32768, 16'sd32767, 0, 16'sd16384, 0, 0, -16'sd32768,
         16'sd32767, 0, 0);
    send(mpsd_pkg::ACT_QUERY, 16'sd32767, -16'sd32768, 16'sd32767, 0, 0, 0, 0, 0, 0, 0);
    send(mpsd_pkg::ACT_APPEND, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd16384, -16'sd16384,
         -16'sd16384, 16'sd100, -16'sd100, 6'd63, 0);
    send(mpsd_pkg::ACT_QUERY, -16'sd32768, 16'sd32767, -16'sd32768, 0, 0, 0, 0, 0, 0, 0);
    send(mpsd_pkg::ACT_APPEND, 0, 0, 0, 16'sd1234, -16'sd32768, 16'sd32767, 16'sd32767,
         16'sd32767, 0, 0);
    send(mpsd_pkg::ACT_QUERY, 16'sd5, -16'sd7, 16'sd9, 0, 0, 0, 0, 0, 0, 0);
    send(mpsd_pkg::ACT_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 6'd63, 0);
    send(mpsd_pkg::ACT_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 6'd1, 0);
    send(mpsd_pkg::ACT_QUERY, 16'sd5, -16'sd7, 16'sd9, 0, 0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 64; i++)
      send(mpsd_pkg::ACT_APPEND, 16'(i * 37), 16'(-i * 91), 16'($urandom), rand_dir(),
           rand_dir(), rand_dir(), -16'sd4000, 16'sd4000, 0, 0);
    send(mpsd_pkg::ACT_APPEND, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(mpsd_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(mpsd_pkg::ACT_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 6'd63, 0);
    send(mpsd_pkg::ACT_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 6'd0, 0);
    send(mpsd_pkg::ACT_QUERY, 16'sd32767, 16'sd32767, 16'sd32767, 0, 0, 0, 0, 0, 0, 0);
    send(mpsd_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(mpsd_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

    // pause until every result has come back
    start <= 1'b0;
    while (pending != 0) @(negedge clk);

    // random traffic, gaps in all but the last part
    for (int i = 0; i < NumRandom; i++) send_random(i < NumRandom * 4 / 5);
    start <= 1'b0;

    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 1000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (80) @(negedge clk);

    $display("ran %0d requests, %0d queries met stored segments", issued, query_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("min_point_segment_distance test passed");
    end else begin
      $display("min_point_segment_distance test failed");
    end
    $finish;
  end
endmodule
